// ----- sv/odi_pkg.sv -----
// Shared types and constants of the odometry integrator.
// Holds the datapath command/status structs, fixed-point constants and the
// Horner reciprocal table; no dependencies.
package odi_pkg;

    // Q2.30 constants
    localparam logic [31:0] Q30_ONE    = 32'd1073741824;
    localparam logic [33:0] Q30_PI     = 34'd3373259426;
    localparam logic [33:0] Q30_HALFPI = 34'd1686629713;
    localparam logic [33:0] Q30_TWOPI  = 34'd6746518852;

    // rate scale factors (microseconds per second, and Q13 to Q16 times that)
    localparam logic signed [33:0] USEC_K = 34'sd1000000;
    localparam logic signed [33:0] YAW_K  = 34'sd8000000;

    // serial divider geometry
    localparam int DIV_NW = 52;
    localparam int DIV_DW = 20;
    localparam int DIV_CW = $clog2(DIV_NW + 1);

    // configuration register indexes and reset values
    localparam logic REG_SPEED  = 1'b0;
    localparam logic REG_MININT = 1'b1;
    localparam logic [15:0] SPEED_RST  = 16'd300;
    localparam logic [15:0] MININT_RST = 16'd500;

    // rate selectors
    localparam logic [1:0] RATE_X   = 2'd0;
    localparam logic [1:0] RATE_Y   = 2'd1;
    localparam logic [1:0] RATE_YAW = 2'd2;

    // last Horner step index
    localparam logic [2:0] HORNER_LAST = 3'd4;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_CHECK,
        OP_MUL_LIM,
        OP_MUL_NX,
        OP_MUL_NY,
        OP_GLX,
        OP_GLY,
        OP_DIV_START,
        OP_DIV_END,
        OP_FOLD,
        OP_MUL_X2,
        OP_X2,
        OP_MUL_T,
        OP_TDIV_START,
        OP_TDIV_END,
        OP_MUL_SV,
        OP_SV,
        OP_PC,
        OP_ROT1,
        OP_ROT2,
        OP_ROT3,
        OP_ROT4,
        OP_ROT5,
        OP_RND,
        OP_POS,
        OP_QUAT,
        OP_OUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic [2:0] idx;
        logic       cos_ph;
        logic       pass;
        logic [1:0] sel;
    } t_dp_cmd;

    typedef struct packed {
        logic skip;
        logic div_busy;
        logic out_free;
    } t_dp_stat;

    // Horner step division by a series constant d: floor(n / d) for any
    // 32-bit n equals (n * ceil(2^s / d)) >> s with s = 32 + ceil(log2(d))
    function automatic logic [32:0] horner_recip(input logic cos_ph,
                                                 input logic [2:0] idx);
        logic [32:0] m;
        case ({cos_ph, idx})
            4'b0_000: m = 33'd4997780127;  // 110
            4'b0_001: m = 33'd7635497416;  // 72
            4'b0_010: m = 33'd6544712071;  // 42
            4'b0_011: m = 33'd6871947674;  // 20
            4'b0_100: m = 33'd5726623062;  // 6
            4'b1_000: m = 33'd8329633544;  // 132
            4'b1_001: m = 33'd6108397933;  // 90
            4'b1_010: m = 33'd4908534053;  // 56
            4'b1_011: m = 33'd4581298450;  // 30
            4'b1_100: m = 33'd5726623062;  // 12
            default:  m = 33'd0;
        endcase
        return m;
    endfunction

    // product shift that goes with horner_recip
    function automatic logic [5:0] horner_shift(input logic cos_ph,
                                                input logic [2:0] idx);
        logic [5:0] s;
        case ({cos_ph, idx})
            4'b0_000: s = 6'd39;
            4'b0_001: s = 6'd39;
            4'b0_010: s = 6'd38;
            4'b0_011: s = 6'd37;
            4'b0_100: s = 6'd35;
            4'b1_000: s = 6'd40;
            4'b1_001: s = 6'd39;
            4'b1_010: s = 6'd38;
            4'b1_011: s = 6'd37;
            4'b1_100: s = 6'd36;
            default:  s = 6'd0;
        endcase
        return s;
    endfunction

endpackage

// ----- sv/odi_div.sv -----
// Restoring serial divider, one quotient bit per cycle, for the rate divisions.
// Runs all dividend bits; uses odi_pkg.
module odi_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [odi_pkg::DIV_NW-1:0]   i_dividend,
    input  logic [odi_pkg::DIV_DW-1:0]   i_divisor,
    output logic                         o_busy,
    output logic [odi_pkg::DIV_NW-1:0]   o_quot
);
    import odi_pkg::*;

    logic [DIV_NW-1:0] r_dq;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_div;
    logic [DIV_CW-1:0] r_cnt;
    logic              r_busy;
    logic [DIV_DW:0]   w_sh;
    logic [DIV_DW:0]   w_diff;
    logic              w_ge;

    // trial subtract of the shifted partial remainder
    assign w_sh   = {r_rem, r_dq[DIV_NW-1]};
    assign w_ge   = (w_sh >= {1'b0, r_div});
    assign w_diff = w_sh - {1'b0, r_div};

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CW'(DIV_NW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == DIV_CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_dq  <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DIV_DW-1:0] : w_sh[DIV_DW-1:0];
            r_dq  <= {r_dq[DIV_NW-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_dq;

endmodule

// ----- sv/odi_dp.sv -----
// Datapath of the odometry integrator: state, shared multiplier, divider,
// trigonometry registers and the output register. Uses odi_pkg and odi_div.
module odi_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  odi_pkg::t_dp_cmd   i_cmd,
    output odi_pkg::t_dp_stat  o_stat,
    input  logic [15:0]        i_speed_limit,
    input  logic [15:0]        i_min_interval_us,
    input  logic signed [31:0] i_fb_x,
    input  logic signed [31:0] i_fb_y,
    input  logic signed [15:0] i_heading,
    input  logic [19:0]        i_elapsed_us,
    input  logic               i_ready,
    output logic               o_valid,
    output logic signed [31:0] o_map_x,
    output logic signed [31:0] o_map_y,
    output logic signed [31:0] o_vel_x,
    output logic signed [31:0] o_vel_y,
    output logic signed [31:0] o_yaw_rate,
    output logic signed [15:0] o_quat_z,
    output logic signed [15:0] o_quat_w,
    output logic               o_glitch_x,
    output logic               o_glitch_y
);
    import odi_pkg::*;

    // latched transaction
    logic signed [31:0] r_fx, r_fy;
    logic signed [15:0] r_h;
    logic [19:0]        r_el;
    // persistent state
    logic               r_started;
    logic signed [31:0] r_prev_x, r_prev_y, r_pos_x, r_pos_y;
    logic signed [15:0] r_prev_h;
    // per-item working registers
    logic signed [32:0] r_dx, r_dy;
    logic               r_gx, r_gy, r_ysn;
    logic [43:0]        r_lim;
    logic [DIV_NW-1:0]  r_nx, r_ny, r_nh;
    logic signed [31:0] r_vx, r_vy, r_vyaw;
    logic [31:0]        r_m, r_x2, r_t, r_sv;
    logic               r_ss, r_cs;
    logic signed [31:0] r_s, r_c;
    logic [65:0]        r_accx, r_accy;
    logic [35:0]        r_rx, r_ry;
    logic [15:0]        r_qz, r_qw;
    logic signed [67:0] r_prod;
    logic               r_out_valid;

    logic signed [33:0] w_mul_a, w_mul_b;
    logic signed [33:0] w_dx34, w_dy34, w_adx, w_ady;
    logic signed [16:0] w_dh, w_adh;
    logic [31:0]        w_pq;
    logic signed [34:0] w_ang, w_angn;
    logic               w_neg, w_gt_pi, w_gt_hp;
    logic [33:0]        w_m0, w_m1, w_m2, w_m3;
    logic [31:0]        w_p, w_cv;
    logic [65:0]        w_rxs, w_rys;
    logic [36:0]        w_px, w_py;
    logic [31:0]        w_qzs, w_qws;
    logic [67:0]        w_tsh;
    logic [31:0]        w_tq;
    logic               w_div_start, w_div_busy;
    logic [DIV_NW-1:0]  w_div_num, w_quot;
    logic [DIV_DW-1:0]  w_div_den;
    logic [DIV_NW-1:0]  w_rnum;
    logic               w_rneg;
    logic signed [31:0] w_rate;

    // saturate a 37-bit sum to 32 bits
    function automatic logic [31:0] sat37(input logic [36:0] v);
        logic [31:0] r;
        if (v[36:31] == 6'b000000 || v[36:31] == 6'b111111) begin
            r = v[31:0];
        end else begin
            r = v[36] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return r;
    endfunction

    // deltas and magnitudes
    assign w_dx34 = {r_dx[32], r_dx};
    assign w_dy34 = {r_dy[32], r_dy};
    assign w_adx  = r_dx[32] ? -w_dx34 : w_dx34;
    assign w_ady  = r_dy[32] ? -w_dy34 : w_dy34;
    assign w_dh   = {r_h[15], r_h} - {r_prev_h[15], r_prev_h};
    assign w_adh  = w_dh[16] ? -w_dh : w_dh;
    assign w_pq   = r_prod[61:30];

    // shared multiplier operand select
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (i_cmd.op)
            OP_MUL_LIM: begin
                w_mul_a = {18'd0, i_speed_limit};
                w_mul_b = {14'd0, r_el};
            end
            OP_MUL_NX: begin
                w_mul_a = w_adx;
                w_mul_b = USEC_K;
            end
            OP_MUL_NY: begin
                w_mul_a = w_ady;
                w_mul_b = USEC_K;
            end
            OP_GLX: begin
                w_mul_a = {17'd0, w_adh};
                w_mul_b = YAW_K;
            end
            OP_MUL_X2: begin
                w_mul_a = {2'b00, r_m};
                w_mul_b = {2'b00, r_m};
            end
            OP_MUL_T: begin
                w_mul_a = {2'b00, r_x2};
                w_mul_b = {2'b00, r_t};
            end
            OP_TDIV_START: begin
                w_mul_a = {2'b00, w_pq};
                w_mul_b = {1'b0, horner_recip(i_cmd.cos_ph, i_cmd.idx)};
            end
            OP_MUL_SV: begin
                w_mul_a = {2'b00, r_m};
                w_mul_b = {2'b00, r_t};
            end
            OP_ROT1: begin
                w_mul_a = w_dx34;
                w_mul_b = {{2{r_c[31]}}, r_c};
            end
            OP_ROT2: begin
                w_mul_a = w_dy34;
                w_mul_b = {{2{r_s[31]}}, r_s};
            end
            OP_ROT3: begin
                w_mul_a = w_dy34;
                w_mul_b = {{2{r_c[31]}}, r_c};
            end
            OP_ROT4: begin
                w_mul_a = w_dx34;
                w_mul_b = {{2{r_s[31]}}, r_s};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // Horner quotient from the reciprocal product
    assign w_tsh = $unsigned(r_prod) >> horner_shift(i_cmd.cos_ph, i_cmd.idx);
    assign w_tq  = w_tsh[31:0];

    // angle fold into the first quadrant
    assign w_ang   = i_cmd.pass ? -{{3{r_h[15]}}, r_h, 16'd0}
                                : {{2{r_h[15]}}, r_h, 17'd0};
    assign w_angn  = -w_ang;
    assign w_neg   = w_ang[34];
    assign w_m0    = w_neg ? w_angn[33:0] : w_ang[33:0];
    assign w_m1    = (w_m0 > Q30_TWOPI) ? Q30_TWOPI : w_m0;
    assign w_gt_pi = (w_m1 > Q30_PI);
    assign w_m2    = w_gt_pi ? (Q30_TWOPI - w_m1) : w_m1;
    assign w_gt_hp = (w_m2 > Q30_HALFPI);
    assign w_m3    = w_gt_hp ? (Q30_PI - w_m2) : w_m2;

    // cosine tail
    assign w_p  = {1'b0, w_pq[31:1]};
    assign w_cv = (w_p < Q30_ONE) ? (Q30_ONE - w_p) : 32'd0;

    // rounding half away from zero: add half, less one when negative
    assign w_rxs = r_accx + 66'd536870912 - {65'd0, r_accx[65]};
    assign w_rys = r_accy + 66'd536870912 - {65'd0, r_accy[65]};
    assign w_qzs = r_s + 32'd32768 - {31'd0, r_s[31]};
    assign w_qws = r_c + 32'd32768 - {31'd0, r_c[31]};

    // saturating position sums
    assign w_px = {{5{r_pos_x[31]}}, r_pos_x} + {r_rx[35], r_rx};
    assign w_py = {{5{r_pos_y[31]}}, r_pos_y} + {r_ry[35], r_ry};

    // rate numerator select and signed saturation of the quotient
    always_comb begin
        case (i_cmd.sel)
            RATE_X: begin
                w_rnum = r_nx;
                w_rneg = r_dx[32];
            end
            RATE_Y: begin
                w_rnum = r_ny;
                w_rneg = r_dy[32];
            end
            default: begin
                w_rnum = r_nh;
                w_rneg = r_ysn;
            end
        endcase
        if (r_el == 20'd0) begin
            w_rate = '0;
        end else if (!w_rneg) begin
            w_rate = (|w_quot[DIV_NW-1:31]) ? 32'sh7FFF_FFFF : {1'b0, w_quot[30:0]};
        end else if ((|w_quot[DIV_NW-1:32]) || (w_quot[31] && (|w_quot[30:0]))) begin
            w_rate = 32'sh8000_0000;
        end else begin
            w_rate = -$signed(w_quot[31:0]);
        end
    end

    // divider operand select
    always_comb begin
        w_div_start = 1'b0;
        w_div_num   = w_rnum;
        w_div_den   = r_el;
        case (i_cmd.op)
            OP_DIV_START: begin
                w_div_start = (r_el != 20'd0);
            end
            default: begin
                w_div_start = 1'b0;
            end
        endcase
    end

    odi_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_num),
        .i_divisor  (w_div_den),
        .o_busy     (w_div_busy),
        .o_quot     (w_quot)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == OP_CHECK) begin
                r_started <= 1'b1;
            end
            if (i_cmd.op == OP_OUT) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // multiplier output register
    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_fx <= i_fb_x;
                r_fy <= i_fb_y;
                r_h  <= i_heading;
                r_el <= i_elapsed_us;
            end
            OP_CHECK: begin
                if (!r_started) begin
                    r_prev_x <= r_fx;
                    r_prev_y <= r_fy;
                    r_pos_x  <= r_fx;
                    r_pos_y  <= r_fy;
                    r_prev_h <= r_h;
                    r_dx     <= '0;
                    r_dy     <= '0;
                end else begin
                    r_dx <= {r_fx[31], r_fx} - {r_prev_x[31], r_prev_x};
                    r_dy <= {r_fy[31], r_fy} - {r_prev_y[31], r_prev_y};
                end
            end
            OP_MUL_NX: begin
                r_lim <= {r_prod[35:0], 8'd0};
            end
            OP_MUL_NY: begin
                r_nx <= r_prod[DIV_NW-1:0];
            end
            OP_GLX: begin
                r_ny     <= r_prod[DIV_NW-1:0];
                r_ysn    <= !w_dh[16] && (w_dh != 17'sd0);
                r_prev_h <= r_h;
                if (r_nx > {8'd0, r_lim}) begin
                    r_gx <= 1'b1;
                    r_dx <= '0;
                    r_nx <= '0;
                end else begin
                    r_gx     <= 1'b0;
                    r_prev_x <= r_fx;
                end
            end
            OP_GLY: begin
                r_nh <= r_prod[DIV_NW-1:0];
                if (r_ny > {8'd0, r_lim}) begin
                    r_gy <= 1'b1;
                    r_dy <= '0;
                    r_ny <= '0;
                end else begin
                    r_gy     <= 1'b0;
                    r_prev_y <= r_fy;
                end
            end
            OP_DIV_END: begin
                case (i_cmd.sel)
                    RATE_X:  r_vx   <= w_rate;
                    RATE_Y:  r_vy   <= w_rate;
                    default: r_vyaw <= w_rate;
                endcase
            end
            OP_FOLD: begin
                r_m  <= w_m3[31:0];
                r_ss <= w_neg ^ w_gt_pi;
                r_cs <= w_gt_hp;
            end
            OP_X2: begin
                r_x2 <= w_pq;
                r_t  <= Q30_ONE;
            end
            OP_TDIV_END: begin
                r_t <= Q30_ONE - w_tq;
            end
            OP_SV: begin
                r_sv <= w_pq;
                r_t  <= Q30_ONE;
            end
            OP_PC: begin
                r_s <= r_ss ? -$signed(r_sv) : $signed(r_sv);
                r_c <= r_cs ? -$signed(w_cv) : $signed(w_cv);
            end
            OP_ROT2: begin
                r_accx <= r_prod[65:0];
            end
            OP_ROT3: begin
                r_accx <= r_accx + r_prod[65:0];
            end
            OP_ROT4: begin
                r_accy <= r_prod[65:0];
            end
            OP_ROT5: begin
                r_accy <= r_accy - r_prod[65:0];
            end
            OP_RND: begin
                r_rx <= w_rxs[65:30];
                r_ry <= w_rys[65:30];
            end
            OP_POS: begin
                r_pos_x <= sat37(w_px);
                r_pos_y <= sat37(w_py);
            end
            OP_QUAT: begin
                r_qz <= w_qzs[31:16];
                r_qw <= w_qws[31:16];
            end
            OP_OUT: begin
                o_map_x    <= r_pos_x;
                o_map_y    <= r_pos_y;
                o_vel_x    <= r_vx;
                o_vel_y    <= r_vy;
                o_yaw_rate <= r_vyaw;
                o_quat_z   <= r_qz;
                o_quat_w   <= r_qw;
                o_glitch_x <= r_gx;
                o_glitch_y <= r_gy;
            end
            default: begin
            end
        endcase
    end

    assign o_valid         = r_out_valid;
    assign o_stat.skip     = (r_el < {4'd0, i_min_interval_us});
    assign o_stat.div_busy = w_div_busy;
    assign o_stat.out_free = !r_out_valid || i_ready;

    // checks
    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_DIV_START) |-> !w_div_busy)
        else $error("divider started while busy");
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_OUT) |=> o_valid)
        else $error("loaded result not presented");
    a_glitch_vel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_glitch_x) |-> (o_vel_x == 32'sd0))
        else $error("rejected x axis has nonzero velocity");
    a_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_started |=> r_started)
        else $error("started flag dropped");
    a_horner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_TDIV_END) |=> (r_t <= Q30_ONE))
        else $error("Horner term above one");

endmodule

// ----- sv/odi_ctrl.sv -----
// Sequencer of the odometry integrator: walks the datapath through gating,
// rejection, rate divisions, two sine/cosine passes, rotation and the quaternion. Uses odi_pkg.
module odi_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  odi_pkg::t_dp_stat i_stat,
    output odi_pkg::t_dp_cmd  o_cmd
);
    import odi_pkg::*;

    typedef enum logic [29:0] {
        ST_IDLE  = 30'd1 << 0,
        ST_CHECK = 30'd1 << 1,
        ST_LIM   = 30'd1 << 2,
        ST_NX    = 30'd1 << 3,
        ST_NY    = 30'd1 << 4,
        ST_GLX   = 30'd1 << 5,
        ST_GLY   = 30'd1 << 6,
        ST_DVS   = 30'd1 << 7,
        ST_DVW   = 30'd1 << 8,
        ST_FOLD  = 30'd1 << 9,
        ST_X2M   = 30'd1 << 10,
        ST_X2    = 30'd1 << 11,
        ST_TM    = 30'd1 << 12,
        ST_TDS   = 30'd1 << 13,
        ST_TDW   = 30'd1 << 14,
        ST_SVM   = 30'd1 << 15,
        ST_SV    = 30'd1 << 16,
        ST_PCM   = 30'd1 << 17,
        ST_PC    = 30'd1 << 18,
        ST_R1    = 30'd1 << 19,
        ST_R2    = 30'd1 << 20,
        ST_R3    = 30'd1 << 21,
        ST_R4    = 30'd1 << 22,
        ST_R5    = 30'd1 << 23,
        ST_RND   = 30'd1 << 24,
        ST_POS   = 30'd1 << 25,
        ST_QUAT  = 30'd1 << 26,
        ST_OUT   = 30'd1 << 27,
        ST_SPARE = 30'd1 << 28,
        ST_HOLD  = 30'd1 << 29
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_idx, n_idx;
    logic       r_cos, n_cos;
    logic       r_pass, n_pass;
    logic [1:0] r_sel, n_sel;
    t_dp_op     w_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_cos   <= 1'b0;
            r_pass  <= 1'b0;
            r_sel   <= RATE_X;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_cos   <= n_cos;
            r_pass  <= n_pass;
            r_sel   <= n_sel;
        end
    end

    // next state and datapath command
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_cos   = r_cos;
        n_pass  = r_pass;
        n_sel   = r_sel;
        w_op    = OP_NONE;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    w_op    = OP_LOAD;
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_stat.skip) begin
                    n_state = ST_IDLE;
                end else begin
                    w_op    = OP_CHECK;
                    n_state = ST_LIM;
                end
            end
            ST_LIM: begin
                w_op    = OP_MUL_LIM;
                n_state = ST_NX;
            end
            ST_NX: begin
                w_op    = OP_MUL_NX;
                n_state = ST_NY;
            end
            ST_NY: begin
                w_op    = OP_MUL_NY;
                n_state = ST_GLX;
            end
            ST_GLX: begin
                w_op    = OP_GLX;
                n_state = ST_GLY;
            end
            ST_GLY: begin
                w_op    = OP_GLY;
                n_sel   = RATE_X;
                n_state = ST_DVS;
            end
            ST_DVS: begin
                w_op    = OP_DIV_START;
                n_state = ST_DVW;
            end
            ST_DVW: begin
                if (!i_stat.div_busy) begin
                    w_op = OP_DIV_END;
                    if (r_sel == RATE_YAW) begin
                        n_pass  = 1'b0;
                        n_state = ST_FOLD;
                    end else begin
                        n_sel   = r_sel + 2'd1;
                        n_state = ST_DVS;
                    end
                end
            end
            ST_FOLD: begin
                w_op    = OP_FOLD;
                n_state = ST_X2M;
            end
            ST_X2M: begin
                w_op    = OP_MUL_X2;
                n_state = ST_X2;
            end
            ST_X2: begin
                w_op    = OP_X2;
                n_idx   = '0;
                n_cos   = 1'b0;
                n_state = ST_TM;
            end
            ST_TM: begin
                w_op    = OP_MUL_T;
                n_state = ST_TDS;
            end
            ST_TDS: begin
                w_op    = OP_TDIV_START;
                n_state = ST_TDW;
            end
            ST_TDW: begin
                if (!i_stat.div_busy) begin
                    w_op = OP_TDIV_END;
                    if (r_idx == HORNER_LAST) begin
                        n_idx   = '0;
                        n_state = r_cos ? ST_PCM : ST_SVM;
                    end else begin
                        n_idx   = r_idx + 3'd1;
                        n_state = ST_TM;
                    end
                end
            end
            ST_SVM: begin
                w_op    = OP_MUL_SV;
                n_state = ST_SV;
            end
            ST_SV: begin
                w_op    = OP_SV;
                n_cos   = 1'b1;
                n_state = ST_TM;
            end
            ST_PCM: begin
                w_op    = OP_MUL_T;
                n_state = ST_PC;
            end
            ST_PC: begin
                w_op    = OP_PC;
                n_state = r_pass ? ST_QUAT : ST_R1;
            end
            ST_R1: begin
                w_op    = OP_ROT1;
                n_state = ST_R2;
            end
            ST_R2: begin
                w_op    = OP_ROT2;
                n_state = ST_R3;
            end
            ST_R3: begin
                w_op    = OP_ROT3;
                n_state = ST_R4;
            end
            ST_R4: begin
                w_op    = OP_ROT4;
                n_state = ST_R5;
            end
            ST_R5: begin
                w_op    = OP_ROT5;
                n_state = ST_RND;
            end
            ST_RND: begin
                w_op    = OP_RND;
                n_state = ST_POS;
            end
            ST_POS: begin
                w_op    = OP_POS;
                n_pass  = 1'b1;
                n_state = ST_FOLD;
            end
            ST_QUAT: begin
                w_op    = OP_QUAT;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_stat.out_free) begin
                    w_op    = OP_OUT;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_cmd.op     = w_op;
    assign o_cmd.idx    = r_idx;
    assign o_cmd.cos_ph = r_cos;
    assign o_cmd.pass   = r_pass;
    assign o_cmd.sel    = r_sel;
    assign o_ready      = (r_state == ST_IDLE);

endmodule

// ----- sv/odometry_integrator_unit.sv -----
// Dead-reckoning odometry integrator, top level.
// New transactions are taken only in the idle state; a skipped item returns straight to it.
// A result waits for the output register to be free. Run time is set mostly by the serial
// divider (one quotient bit per cycle) running the three 52-bit rate divisions.
// Reset (synchronous, active low): unseeded, no result pending, registers 300 and 500.
// Holds the configuration registers; uses odi_pkg, odi_ctrl and odi_dp.
module odometry_integrator_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // input channel
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_fb_x,
    input  logic signed [31:0] i_fb_y,
    input  logic signed [15:0] i_heading,
    input  logic [19:0]        i_elapsed_us,
    // result channel
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_map_x,
    output logic signed [31:0] o_map_y,
    output logic signed [31:0] o_vel_x,
    output logic signed [31:0] o_vel_y,
    output logic signed [31:0] o_yaw_rate,
    output logic signed [15:0] o_quat_z,
    output logic signed [15:0] o_quat_w,
    output logic               o_glitch_x,
    output logic               o_glitch_y
);
    import odi_pkg::*;

    logic [15:0] r_speed_limit;
    logic [15:0] r_min_interval_us;
    t_dp_cmd     w_cmd;
    t_dp_stat    w_stat;

    // configuration registers, written in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_limit     <= SPEED_RST;
            r_min_interval_us <= MININT_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_SPEED:  r_speed_limit     <= pwdata[15:0];
                REG_MININT: r_min_interval_us <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // register readback
    always_comb begin
        case (paddr[2])
            REG_SPEED:  prdata = {16'd0, r_speed_limit};
            REG_MININT: prdata = {16'd0, r_min_interval_us};
            default:    prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    odi_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    odi_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_speed_limit     (r_speed_limit),
        .i_min_interval_us (r_min_interval_us),
        .i_fb_x            (i_fb_x),
        .i_fb_y            (i_fb_y),
        .i_heading         (i_heading),
        .i_elapsed_us      (i_elapsed_us),
        .i_ready           (i_ready),
        .o_valid           (o_valid),
        .o_map_x           (o_map_x),
        .o_map_y           (o_map_y),
        .o_vel_x           (o_vel_x),
        .o_vel_y           (o_vel_y),
        .o_yaw_rate        (o_yaw_rate),
        .o_quat_z          (o_quat_z),
        .o_quat_w          (o_quat_w),
        .o_glitch_x        (o_glitch_x),
        .o_glitch_y        (o_glitch_y)
    );

endmodule
